FILE: design/cvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvt_pkg
// Shared types and constants of the camera view transform unit.
// ----------------------------------------------------------------------------
package cvt_pkg;

    // Command codes carried in the low bits of s_tuser.
    typedef enum logic [1:0] {
        CMD_VISIBLE  = 2'd0,
        CMD_TO_WORLD = 2'd1,
        CMD_PAN      = 2'd2,
        CMD_ZOOM     = 2'd3
    } cmd_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ZOOM_FLOOR    = 2'd2;
    localparam logic [1:0] CFG_ZOOM_CEILING  = 2'd3;

    localparam int SCREEN_W = 13;
    localparam int ZOOM_W   = 24;
    localparam int POS_W    = 32;

    localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 13'd1280;
    localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 13'd720;
    localparam logic [ZOOM_W-1:0]   ZOOM_FLOOR_RST    = 24'd1966;
    localparam logic [ZOOM_W-1:0]   ZOOM_CEILING_RST  = 24'd655360;
    localparam logic [ZOOM_W-1:0]   ZOOM_ONE          = 24'd65536;
    localparam logic [ZOOM_W-1:0]   ZOOM_MAX          = 24'hFFFFFF;

    // 1.1 in Q16.16 and half of it for rounding the zoom-out quotient.
    localparam logic [16:0] ONE_POINT_ONE  = 17'd72090;
    localparam logic [16:0] HALF_POINT_ONE = 17'd36045;

    // Shared divider geometry: 48-bit dividend, 24-bit divisor, two bits a cycle.
    localparam int DIV_DVD_W = 48;
    localparam int DIV_DVS_W = 24;
    localparam int DIV_STEPS = 2;

    // Width of the wide position accumulator.
    localparam int ACC_W = 52;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sh7FFFFFFF);
        lo = -ACC_W'(64'sh80000000);
        if (v > hi)
        begin
            return 32'sh7FFFFFFF;
        end
        else if (v < lo)
        begin
            return 32'sh80000000;
        end
        return v[POS_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/cvt_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cvt_divider
// Unsigned restoring divider, STEPS quotient bits per cycle.
// ----------------------------------------------------------------------------
module cvt_divider #(
    parameter int DVD_W = cvt_pkg::DIV_DVD_W,
    parameter int DVS_W = cvt_pkg::DIV_DVS_W,
    parameter int STEPS = cvt_pkg::DIV_STEPS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DVD_W-1:0]  dividend,
    input  wire logic [DVS_W-1:0]  divisor,
    output logic [DVD_W-1:0]       quotient,
    output cvt_pkg::div_stat_t     stat
);

    localparam int ROUNDS = DVD_W / STEPS;
    localparam int CNT_W  = $clog2(ROUNDS + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] quo_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   trial;
    logic             last_round;

    assign last_round = (cnt_reg == CNT_W'(ROUNDS - 1));

    // The quotient register holds the unused dividend bits at its top and
    // collects quotient bits at its bottom.
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int i = 0; i < STEPS; i++)
        begin
            trial    = {rem_next, quo_next[DVD_W-1]};
            quo_next = {quo_next[DVD_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial       = trial - {1'b0, dvs_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last_round)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

FILE: design/camera_view_transform_unit_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// camera_view_transform_unit_core
// 2D camera with pan and zoom: visibility test, screen to world, pan, zoom.
// ----------------------------------------------------------------------------
// Usage:
// One command word enters on the s_ group; one result word leaves on the m_
// group for every command. s_tready is high only while the block is idle.
// The configuration channel (cfg_valid, cfg_index, cfg_data) is always ready
// and should be written only while no command is in flight.
// Every division by zoom runs on one shared divider that retires two
// quotient bits a cycle. Visibility, screen to world and pan need two
// divisions. Zoom needs two divisions with the old zoom, one more for
// zooming out, and two with the new zoom. The result sits in an output
// register; a new command is taken while it waits, and that command
// stalls in its final step until the register frees.
// Reset restores the register defaults, puts the camera at the origin with a
// zoom of one and empties the output register.
// ----------------------------------------------------------------------------
module camera_view_transform_unit_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Command words.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // point_x [31:0], point_y [63:32], box_width [95:64], box_height [127:96]
    input  wire logic [127:0] s_tdata,
    // cmd [1:0], zoom_in [2]
    input  wire logic [2:0]   s_tuser,
    // Result words.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // visible [0], out_x [32:1], out_y [64:33], zoom_level [88:65], zero [95:89]
    output logic [95:0]       m_tdata,
    // Configuration writes.
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [23:0]  cfg_data
);

    localparam int DVD_W = cvt_pkg::DIV_DVD_W;
    localparam int DVS_W = cvt_pkg::DIV_DVS_W;
    localparam int ACC_W = cvt_pkg::ACC_W;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DIVX   = 7'b0000010,
        ST_DIVY   = 7'b0000100,
        ST_ZMUL   = 7'b0001000,
        ST_ZDIV   = 7'b0010000,
        ST_ZCLAMP = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t                state_reg;
    state_t                state_next;

    logic [12:0]           sw_reg;
    logic [12:0]           sh_reg;
    logic [23:0]           floor_reg;
    logic [23:0]           ceil_reg;

    logic signed [31:0]    cam_x_reg;
    logic signed [31:0]    cam_y_reg;
    logic [23:0]           zoom_reg;
    logic                  pass_reg;
    logic                  issued_reg;
    logic                  out_valid_reg;
    logic [95:0]           out_data_reg;

    cvt_pkg::cmd_t         cmd_reg;
    logic                  zin_reg;
    logic signed [31:0]    px_reg;
    logic signed [31:0]    py_reg;
    logic [31:0]           bw_reg;
    logic [31:0]           bh_reg;
    logic signed [33:0]    vx_reg;
    logic signed [33:0]    vy_reg;
    logic signed [ACC_W-1:0] ax_reg;
    logic signed [ACC_W-1:0] ay_reg;
    logic [40:0]           prod_reg;

    logic                  in_fire;
    logic                  div_start;
    logic [DVD_W-1:0]      div_dividend;
    logic [DVS_W-1:0]      div_divisor;
    logic [DVD_W-1:0]      div_quotient;
    cvt_pkg::div_stat_t    div_stat;
    logic signed [33:0]    div_src;
    logic signed [33:0]    div_mag;
    logic signed [DVD_W:0] q_signed;
    logic signed [ACC_W-1:0] q_ext;
    logic signed [ACC_W-1:0] acc_base;
    logic signed [ACC_W-1:0] acc_new;

    logic signed [33:0]    px_ext;
    logic signed [33:0]    py_ext;
    logic signed [33:0]    half_w;
    logic signed [33:0]    half_h;
    logic signed [33:0]    vx_init;
    logic signed [33:0]    vy_init;

    logic [40:0]           zin_sum;
    logic [24:0]           zin_shift;
    logic [23:0]           zoom_cand;
    logic [23:0]           zoom_floored;
    logic [23:0]           zoom_clamped;

    logic signed [52:0]    px2;
    logic signed [52:0]    py2;
    logic signed [52:0]    cx2;
    logic signed [52:0]    cy2;
    logic signed [52:0]    bw_ext;
    logic signed [52:0]    bh_ext;
    logic signed [52:0]    vw_ext;
    logic signed [52:0]    vh_ext;
    logic                  vis;
    logic signed [31:0]    res_x;
    logic signed [31:0]    res_y;
    logic                  out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign out_free  = !out_valid_reg || m_tready;

    // Operand setup for the incoming word.
    assign px_ext  = 34'(signed'(s_tdata[31:0]));
    assign py_ext  = 34'(signed'(s_tdata[63:32]));
    assign half_w  = $signed({6'b0, sw_reg, 15'b0});
    assign half_h  = $signed({6'b0, sh_reg, 15'b0});

    always_comb
    begin
        case (cvt_pkg::cmd_t'(s_tuser[1:0]))
            cvt_pkg::CMD_VISIBLE:
            begin
                vx_init = $signed({5'b0, sw_reg, 16'b0});
                vy_init = $signed({5'b0, sh_reg, 16'b0});
            end
            cvt_pkg::CMD_PAN:
            begin
                vx_init = px_ext;
                vy_init = py_ext;
            end
            default:
            begin
                vx_init = px_ext - half_w;
                vy_init = py_ext - half_h;
            end
        endcase
    end

    // Divider operands. Signed values divide as magnitudes; the sign is
    // restored on the quotient so the result truncates toward zero.
    assign div_src = (state_reg == ST_DIVY) ? vy_reg : vx_reg;
    assign div_mag = div_src[33] ? -div_src : div_src;

    always_comb
    begin
        if (state_reg == ST_ZDIV)
        begin
            div_dividend = DVD_W'({zoom_reg, 16'b0} + 40'(cvt_pkg::HALF_POINT_ONE));
            div_divisor  = DVS_W'(cvt_pkg::ONE_POINT_ONE);
        end
        else
        begin
            div_dividend = {div_mag[31:0], 16'b0};
            div_divisor  = zoom_reg;
        end
    end

    assign div_start = ((state_reg == ST_DIVX) || (state_reg == ST_DIVY)
                        || (state_reg == ST_ZDIV)) && !issued_reg;

    assign q_signed = div_src[33] ? -$signed({1'b0, div_quotient})
                                  : $signed({1'b0, div_quotient});
    assign q_ext    = ACC_W'(q_signed);

    // Accumulator update when a position division finishes.
    always_comb
    begin
        acc_base = (state_reg == ST_DIVY) ? ACC_W'(cam_y_reg) : ACC_W'(cam_x_reg);
        case (cmd_reg)
            cvt_pkg::CMD_VISIBLE:  acc_new = q_ext;
            cvt_pkg::CMD_TO_WORLD: acc_new = acc_base + q_ext;
            cvt_pkg::CMD_PAN:      acc_new = acc_base - q_ext;
            default:
            begin
                if (pass_reg)
                begin
                    acc_new = ((state_reg == ST_DIVY) ? ay_reg : ax_reg) - q_ext;
                end
                else
                begin
                    acc_new = acc_base + q_ext;
                end
            end
        endcase
    end

    // New zoom: scale, saturate when zooming in, then floor and ceiling, never zero.
    assign zin_sum   = prod_reg + 41'd32768;
    assign zin_shift = zin_sum[40:16];

    always_comb
    begin
        if (zin_reg)
        begin
            zoom_cand = (zin_shift > {1'b0, cvt_pkg::ZOOM_MAX}) ? cvt_pkg::ZOOM_MAX
                                                              : zin_shift[23:0];
        end
        else
        begin
            zoom_cand = div_quotient[23:0];
        end
        zoom_floored = (zoom_cand < floor_reg) ? floor_reg : zoom_cand;
        zoom_clamped = (zoom_floored > ceil_reg) ? ceil_reg : zoom_floored;
        if (zoom_clamped == '0)
        begin
            zoom_clamped = 24'd1;
        end
    end

    // Visibility in doubled coordinates so the half sizes stay exact.
    assign px2    = $signed({{20{px_reg[31]}}, px_reg, 1'b0});
    assign py2    = $signed({{20{py_reg[31]}}, py_reg, 1'b0});
    assign cx2    = $signed({{20{cam_x_reg[31]}}, cam_x_reg, 1'b0});
    assign cy2    = $signed({{20{cam_y_reg[31]}}, cam_y_reg, 1'b0});
    assign bw_ext = $signed({21'b0, bw_reg});
    assign bh_ext = $signed({21'b0, bh_reg});
    assign vw_ext = $signed({ax_reg[ACC_W-1], ax_reg});
    assign vh_ext = $signed({ay_reg[ACC_W-1], ay_reg});

    assign vis = ((px2 + bw_ext) > (cx2 - vw_ext)) && ((py2 + bh_ext) > (cy2 - vh_ext))
              && ((px2 - bw_ext) < (cx2 + vw_ext)) && ((py2 - bh_ext) < (cy2 + vh_ext));

    assign res_x = cvt_pkg::sat32(ax_reg);
    assign res_y = cvt_pkg::sat32(ay_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_DIVX;
                end
            end
            ST_DIVX:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (div_stat.done)
                begin
                    if ((cmd_reg == cvt_pkg::CMD_ZOOM) && !pass_reg)
                    begin
                        state_next = zin_reg ? ST_ZMUL : ST_ZDIV;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_ZMUL:
            begin
                state_next = ST_ZCLAMP;
            end
            ST_ZDIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_ZCLAMP;
                end
            end
            ST_ZCLAMP:
            begin
                state_next = ST_DIVX;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sw_reg        <= cvt_pkg::SCREEN_WIDTH_RST;
            sh_reg        <= cvt_pkg::SCREEN_HEIGHT_RST;
            floor_reg     <= cvt_pkg::ZOOM_FLOOR_RST;
            ceil_reg      <= cvt_pkg::ZOOM_CEILING_RST;
            cam_x_reg     <= '0;
            cam_y_reg     <= '0;
            zoom_reg      <= cvt_pkg::ZOOM_ONE;
            pass_reg      <= 1'b0;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cvt_pkg::CFG_SCREEN_WIDTH:  sw_reg    <= cfg_data[12:0];
                    cvt_pkg::CFG_SCREEN_HEIGHT: sh_reg    <= cfg_data[12:0];
                    cvt_pkg::CFG_ZOOM_FLOOR:    floor_reg <= cfg_data;
                    cvt_pkg::CFG_ZOOM_CEILING:  ceil_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (div_start)
            begin
                issued_reg <= 1'b1;
            end
            else if (div_stat.done)
            begin
                issued_reg <= 1'b0;
            end
            if (in_fire)
            begin
                pass_reg <= 1'b0;
            end
            if (state_reg == ST_ZCLAMP)
            begin
                zoom_reg <= zoom_clamped;
                pass_reg <= 1'b1;
            end
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
                if ((cmd_reg == cvt_pkg::CMD_PAN) || (cmd_reg == cvt_pkg::CMD_ZOOM))
                begin
                    cam_x_reg <= res_x;
                    cam_y_reg <= res_y;
                end
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= cvt_pkg::cmd_t'(s_tuser[1:0]);
            zin_reg <= s_tuser[2];
            px_reg  <= s_tdata[31:0];
            py_reg  <= s_tdata[63:32];
            bw_reg  <= s_tdata[95:64];
            bh_reg  <= s_tdata[127:96];
            vx_reg  <= vx_init;
            vy_reg  <= vy_init;
        end
        if ((state_reg == ST_DIVX) && div_stat.done)
        begin
            ax_reg <= acc_new;
        end
        if ((state_reg == ST_DIVY) && div_stat.done)
        begin
            ay_reg <= acc_new;
        end
        if (state_reg == ST_ZMUL)
        begin
            prod_reg <= zoom_reg * cvt_pkg::ONE_POINT_ONE;
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            if (cmd_reg == cvt_pkg::CMD_VISIBLE)
            begin
                out_data_reg <= {7'b0, zoom_reg, 32'b0, 32'b0, vis};
            end
            else
            begin
                out_data_reg <= {7'b0, zoom_reg, res_y, res_x, 1'b0};
            end
        end
    end

    cvt_divider #(
        .DVD_W (cvt_pkg::DIV_DVD_W),
        .DVS_W (cvt_pkg::DIV_DVS_W),
        .STEPS (cvt_pkg::DIV_STEPS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

`ifndef SYNTH
    // Zoom must never reach zero, or a later division would fail.
    a_zoom_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        zoom_reg != '0)
        else $error("zoom register reached zero");

    // The sequencer must not restart the divider while it runs.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // A finished division only arrives while the sequencer waits for one.
    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> ((state_reg == ST_DIVX) || (state_reg == ST_DIVY)
                           || (state_reg == ST_ZDIV)))
        else $error("division finished outside a divide step");

    // After the new zoom is set, the second pass of position divisions runs.
    a_second_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ZCLAMP) |=> ((state_reg == ST_DIVX) && pass_reg))
        else $error("zoom update not followed by the second pass");
`endif

endmodule
`default_nettype wire

FILE: bench/cvt_view_checker.sv
// ----------------------------------------------------------------------------
// cvt_view_checker
// Watches the command, result and configuration channels of the camera view
// transform unit. It keeps its own copy of the camera and of the registers,
// works out the result word of every accepted command and compares each
// accepted result word with the oldest outstanding one.
// ----------------------------------------------------------------------------
module cvt_view_checker
    import cvt_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [127:0] s_tdata,
    input  wire logic [2:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [95:0]  m_tdata,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [23:0]  cfg_data,
    output int                errors,
    output int                pending
);

    localparam longint ZOOM_STEP      = 72090;
    localparam longint ZOOM_STEP_HALF = 36045;
    localparam longint ZOOM_SAT       = 64'hFFFFFF;

    typedef struct packed {
        logic               visible;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [23:0]        zoom;
    } view_result_t;

    logic [12:0]        scr_w;
    logic [12:0]        scr_h;
    logic [23:0]        zoom_lo;
    logic [23:0]        zoom_hi;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic [23:0]        zoom;

    view_result_t expected_views[$];

    // Value divided by the Q8.16 zoom, truncated toward zero.
    function automatic longint over_zoom(input longint v, input logic [23:0] z);
        longint d;
        d = z;
        if (d == 0)
        begin
            d = 1;
        end
        return (v * 65536) / d;
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sh7FFFFFFF)
        begin
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sh80000000)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Applies one command to the camera copy and returns its result word.
    function automatic view_result_t step_camera(
        input cmd_t               cmd,
        input logic signed [31:0] px,
        input logic signed [31:0] py,
        input logic [31:0]        bw,
        input logic [31:0]        bh,
        input logic               zin
    );
        view_result_t r;
        longint x, y, w, h, cx, cy, half_w, half_h, vw, vh;
        longint offx, offy, wx, wy, z;
        r = '0;
        x = px;
        y = py;
        w = bw;
        h = bh;
        cx = cam_x;
        cy = cam_y;
        half_w = scr_w;
        half_w = half_w * 32768;
        half_h = scr_h;
        half_h = half_h * 32768;
        case (cmd)
            CMD_VISIBLE:
            begin
                // Both boxes are kept at twice their scale so that halving stays exact.
                vw = over_zoom(half_w * 2, zoom);
                vh = over_zoom(half_h * 2, zoom);
                r.visible = (2 * x + w > 2 * cx - vw) && (2 * y + h > 2 * cy - vh)
                         && (2 * x - w < 2 * cx + vw) && (2 * y - h < 2 * cy + vh);
            end
            CMD_TO_WORLD:
            begin
                r.x = clip32(cx + over_zoom(x - half_w, zoom));
                r.y = clip32(cy + over_zoom(y - half_h, zoom));
            end
            CMD_PAN:
            begin
                cam_x = clip32(cx - over_zoom(x, zoom));
                cam_y = clip32(cy - over_zoom(y, zoom));
                r.x = cam_x;
                r.y = cam_y;
            end
            default:
            begin
                offx = x - half_w;
                offy = y - half_h;
                wx = cx + over_zoom(offx, zoom);
                wy = cy + over_zoom(offy, zoom);
                z = zoom;
                if (zin)
                begin
                    z = (z * ZOOM_STEP + 32768) >>> 16;
                    if (z > ZOOM_SAT)
                    begin
                        z = ZOOM_SAT;
                    end
                end
                else
                begin
                    z = (z * 65536 + ZOOM_STEP_HALF) / ZOOM_STEP;
                end
                // The ceiling is applied last, so it wins over a higher floor.
                if (z < longint'(zoom_lo))
                begin
                    z = zoom_lo;
                end
                if (z > longint'(zoom_hi))
                begin
                    z = zoom_hi;
                end
                if (z == 0)
                begin
                    z = 1;
                end
                zoom = z[23:0];
                cam_x = clip32(wx - over_zoom(offx, zoom));
                cam_y = clip32(wy - over_zoom(offy, zoom));
                r.x = cam_x;
                r.y = cam_y;
            end
        endcase
        r.zoom = zoom;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        view_result_t want;
        view_result_t got;
        if (!rst_n)
        begin
            scr_w = SCREEN_WIDTH_RST;
            scr_h = SCREEN_HEIGHT_RST;
            zoom_lo = ZOOM_FLOOR_RST;
            zoom_hi = ZOOM_CEILING_RST;
            cam_x = '0;
            cam_y = '0;
            zoom = ZOOM_ONE;
            expected_views.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            // Results are compared before the command of this edge is queued.
            if (m_tvalid && m_tready)
            begin
                got.visible = m_tdata[0];
                got.x = m_tdata[32:1];
                got.y = m_tdata[64:33];
                got.zoom = m_tdata[88:65];
                if (expected_views.size() == 0)
                begin
                    $error("result word with no command outstanding: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_views.pop_front();
                    if (got.visible !== want.visible)
                    begin
                        $error("visible mismatch: expected %0d, got %0d",
                               want.visible, got.visible);
                        errors++;
                    end
                    if (got.x !== want.x)
                    begin
                        $error("out_x mismatch: expected %0d, got %0d", want.x, got.x);
                        errors++;
                    end
                    if (got.y !== want.y)
                    begin
                        $error("out_y mismatch: expected %0d, got %0d", want.y, got.y);
                        errors++;
                    end
                    if (got.zoom !== want.zoom)
                    begin
                        $error("zoom_level mismatch: expected %0d, got %0d",
                               want.zoom, got.zoom);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH:  scr_w = cfg_data[12:0];
                    CFG_SCREEN_HEIGHT: scr_h = cfg_data[12:0];
                    CFG_ZOOM_FLOOR:    zoom_lo = cfg_data;
                    CFG_ZOOM_CEILING:  zoom_hi = cfg_data;
                    default:           ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                expected_views.push_back(step_camera(cmd_t'(s_tuser[1:0]),
                    s_tdata[31:0], s_tdata[63:32], s_tdata[95:64], s_tdata[127:96],
                    s_tuser[2]));
            end
            pending = expected_views.size();
        end
    end

endmodule

FILE: bench/tb_camera_view_transform_unit_core.sv
// ----------------------------------------------------------------------------
// tb_camera_view_transform_unit_core
// Drives camera commands and register writes into the view transform unit:
// a directed pass over the extremes and clamping cases, then random
// commands under four register settings with different idling on each side.
// The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_camera_view_transform_unit_core;
    import cvt_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic [95:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [23:0]  cfg_data = '0;

    int errors;
    int pending;
    int gap_pct = 0;
    int stall_pct = 0;

    localparam logic [31:0] MIN_S = 32'h8000_0000;
    localparam logic [31:0] MAX_S = 32'h7FFF_FFFF;
    localparam logic [31:0] ALL1  = 32'hFFFF_FFFF;

    camera_view_transform_unit_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cvt_view_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_cmd(input cmd_t cmd, input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] bw, input logic [31:0] bh,
                            input logic zin);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {bh, bw, py, px};
        s_tuser <= {zin, cmd};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Holds off new commands until every result word has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic set_view(input logic [12:0] w, input logic [12:0] h,
                            input logic [23:0] lo, input logic [23:0] hi);
        drain();
        write_reg(CFG_SCREEN_WIDTH, 24'(w));
        write_reg(CFG_SCREEN_HEIGHT, 24'(h));
        write_reg(CFG_ZOOM_FLOOR, lo);
        write_reg(CFG_ZOOM_CEILING, hi);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly values within +-span, with some full-range words and extremes.
    function automatic logic [31:0] pick_coord(input logic [31:0] span);
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
        begin
            return $urandom;
        end
        if (k == 1)
        begin
            case ($urandom_range(0, 3))
                0:       return MIN_S;
                1:       return MAX_S;
                2:       return '0;
                default: return ALL1;
            endcase
        end
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic logic [31:0] pick_size();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
        begin
            return $urandom;
        end
        if (k == 1)
        begin
            return $urandom_range(0, 1) ? ALL1 : '0;
        end
        return $urandom_range(0, 32'h0400_0000);
    endfunction

    task automatic random_cmds(input int count);
        cmd_t cmd;
        logic [31:0] px, py;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
            begin
                drain();
            end
            cmd = cmd_t'($urandom_range(0, 3));
            if (cmd == CMD_PAN)
            begin
                px = pick_coord(32'h0100_0000);
                py = pick_coord(32'h0100_0000);
            end
            else
            begin
                px = pick_coord(32'h0800_0000);
                py = pick_coord(32'h0800_0000);
            end
            send_cmd(cmd, px, py, pick_size(), pick_size(), 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        #60_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed pass at reset settings.
        set_view(13'd1280, 13'd720, 24'd1966, 24'd655360);
        send_cmd(CMD_VISIBLE, '0, '0, '0, '0, 1'b0);
        send_cmd(CMD_VISIBLE, MAX_S, MIN_S, ALL1, ALL1, 1'b1);
        send_cmd(CMD_VISIBLE, MIN_S, MAX_S, '0, '0, 1'b0);
        send_cmd(CMD_TO_WORLD, MAX_S, MIN_S, ALL1, '0, 1'b1);
        send_cmd(CMD_TO_WORLD, MIN_S, MAX_S, '0, ALL1, 1'b0);
        send_cmd(CMD_PAN, MIN_S, MIN_S, '0, '0, 1'b0);
        send_cmd(CMD_PAN, MAX_S, MAX_S, '0, '0, 1'b1);
        send_cmd(CMD_ZOOM, '0, '0, '0, '0, 1'b1);
        send_cmd(CMD_ZOOM, MAX_S, MIN_S, '0, '0, 1'b0);

        // Zero floor and ceiling: zoom falls to its smallest step.
        set_view(13'd1280, 13'd720, 24'd0, 24'd0);
        send_cmd(CMD_ZOOM, 32'h0280_0000, 32'h0168_0000, '0, '0, 1'b1);
        send_cmd(CMD_PAN, MIN_S, MIN_S, '0, '0, 1'b0);
        send_cmd(CMD_TO_WORLD, MAX_S, MAX_S, '0, '0, 1'b0);
        send_cmd(CMD_VISIBLE, '0, '0, 32'h0001_0000, 32'h0001_0000, 1'b0);

        // Zoom near the top of its range, so that multiplying saturates.
        set_view(13'd4096, 13'd1, 24'hFFFF00, 24'hFFFFFF);
        send_cmd(CMD_ZOOM, '0, '0, '0, '0, 1'b1);
        send_cmd(CMD_ZOOM, MIN_S, MAX_S, '0, '0, 1'b1);
        send_cmd(CMD_ZOOM, '0, '0, '0, '0, 1'b0);

        // Floor above ceiling with a zero-sized screen.
        set_view(13'd0, 13'd0, 24'h800000, 24'h010000);
        send_cmd(CMD_ZOOM, 32'h0001_0000, 32'hFFFF_0000, '0, '0, 1'b0);
        send_cmd(CMD_VISIBLE, '0, '0, ALL1, ALL1, 1'b1);
        send_cmd(CMD_VISIBLE, '0, '0, '0, '0, 1'b0);
        send_cmd(CMD_TO_WORLD, 32'h1234_5678, 32'hEDCB_A987, '0, '0, 1'b1);

        // Random phases, each with its own settings and idling.
        set_view(13'd1280, 13'd720, 24'd1966, 24'd655360);
        gap_pct = 0;
        stall_pct = 0;
        random_cmds(350);

        set_view(13'd1, 13'd4096, 24'd1, 24'hFFFFFF);
        gap_pct = 54;
        stall_pct = 0;
        random_cmds(350);

        set_view(13'h1FFF, 13'd0, 24'd0, 24'h020000);
        gap_pct = 0;
        stall_pct = 54;
        random_cmds(350);

        set_view(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                 24'($urandom_range(1, 65536)), 24'($urandom_range(65536, 24'hFFFFFF)));
        gap_pct = 34;
        stall_pct = 34;
        random_cmds(350);

        drain();
        repeat (300) @(negedge clk);
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
